// ----- rtl/core/plti_pkg.sv -----
// Shared types, codes and sizes for the piecewise linear table interpolator.
package plti_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int VALUE_WIDTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int PROD_W      = 2 * VALUE_WIDTH;
	localparam int STEP_W      = $clog2(PROD_W);
	localparam int SUM_W       = PROD_W + 2;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic        [VALUE_WIDTH-1:0] mag_t;
	typedef logic        [PROD_W-1:0]      prod_t;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_QUERY = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_FEW   = 3'd2,
		ST_ZERO  = 3'd3,
		ST_SAT   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEL,
		S_MUL,
		S_DIVGO,
		S_DIV,
		S_FIN
	} state_t;

	// Command broadcast to every table cell.
	typedef struct packed {
		logic   load;
		value_t px;
		value_t py;
	} cell_cmd_t;

endpackage

// ----- rtl/core/piecewise_linear_table_interpolator.sv -----
// Top level of the piecewise linear table interpolator: cell row, segment pick, multiply, divide and saturate.
// Clear and load words never raise busy: the result strobes in the cycle after the word is taken.
// A query steps through segment pick, multiply, divider launch, the 32-step restoring divider
// (one quotient bit per cycle) and final add before its result strobe; busy is
// high throughout. Queries with fewer than two points or on a zero-width segment finish sooner.
// Loads never raise busy because every cell in the row compares and shifts at once. The
// receiver cannot stall: done is high for a single cycle, and the result stays until the next word is taken.
module piecewise_linear_table_interpolator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           func,
	input  logic signed [15:0]   point_x,
	input  logic signed [15:0]   point_y,
	output logic                 done,
	output logic signed [15:0]   result_y,
	output logic [7:0]           segment_low,
	output logic [2:0]           status
);
	import plti_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	value_t           px_q;
	cell_cmd_t        cmd;
	logic             accept;
	logic             full;

	value_t cx [TABLE_DEPTH];
	value_t cy [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] cle;
	logic [TABLE_DEPTH-1:0] cgt;
	logic [TABLE_DEPTH-1:0] cvalid;
	logic [TABLE_DEPTH:0]   g_ext;
	logic [TABLE_DEPTH:0]   last_ext;
	logic [TABLE_DEPTH-1:0] sel;

	value_t           xlo_c, xhi_c, ylo_c, yhi_c;
	logic [IDX_W-1:0] seg_c;
	value_t           xlo_q, xhi_q, ylo_q, yhi_q;
	logic [IDX_W-1:0] seg_q;

	logic signed [VALUE_WIDTH:0] dx_c, dy_c, a_c;
	mag_t  dxm_c, dym_c, am_c;
	prod_t prod_q;
	mag_t  dxm_q;
	logic  neg_q;
	logic  zero_q;

	logic  div_go;
	logic  div_done;
	prod_t quo;

	logic signed [SUM_W-1:0] sum_c;
	logic signed [SUM_W-1:0] lim_hi, lim_lo;

	assign accept = start && !busy;
	assign full   = count_q >= CNT_W'(TABLE_DEPTH);

	assign cmd.load = accept && (func == FUNC_LOAD) && !full;
	assign cmd.px   = (state_q == S_IDLE) ? value_t'(point_x) : px_q;
	assign cmd.py   = value_t'(point_y);

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			assign cvalid[gi] = CNT_W'(gi) < count_q;
			if (gi == 0) begin : g_first
				plti_cell u_cell (
					.clk(clk), .cmd(cmd), .valid(cvalid[gi]),
					.prev_le(1'b1), .prev_x(cmd.px), .prev_y(cmd.py),
					.x(cx[gi]), .y(cy[gi]), .le(cle[gi]), .gt(cgt[gi])
				);
			end else begin : g_rest
				plti_cell u_cell (
					.clk(clk), .cmd(cmd), .valid(cvalid[gi]),
					.prev_le(cle[gi-1]), .prev_x(cx[gi-1]), .prev_y(cy[gi-1]),
					.x(cx[gi]), .y(cy[gi]), .le(cle[gi]), .gt(cgt[gi])
				);
			end
		end
	endgenerate

	// The compare flags form a thermometer; the lower segment end is picked by looking at the
	// neighbour only, clamped to the first and last segment for extrapolation.
	always_comb begin
		g_ext    = {1'b0, cgt};
		last_ext = {1'b0, cvalid & ~{1'b0, cvalid[TABLE_DEPTH-1:1]}};
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			sel[i] = (g_ext[i] && !g_ext[i+1] && !last_ext[i])
				|| (g_ext[i] && g_ext[i+1] && last_ext[i+1])
				|| ((i == 0) && !g_ext[0]);
		end
	end

	always_comb begin
		xlo_c = '0;
		xhi_c = '0;
		ylo_c = '0;
		yhi_c = '0;
		seg_c = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (sel[i]) begin
				xlo_c = xlo_c | cx[i];
				ylo_c = ylo_c | cy[i];
				seg_c = seg_c | IDX_W'(i);
			end
		end
		for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
			if (sel[i]) begin
				xhi_c = xhi_c | cx[i+1];
				yhi_c = yhi_c | cy[i+1];
			end
		end
	end

	assign dx_c  = {xhi_q[VALUE_WIDTH-1], xhi_q} - {xlo_q[VALUE_WIDTH-1], xlo_q};
	assign dy_c  = {yhi_q[VALUE_WIDTH-1], yhi_q} - {ylo_q[VALUE_WIDTH-1], ylo_q};
	assign a_c   = {px_q[VALUE_WIDTH-1], px_q} - {xlo_q[VALUE_WIDTH-1], xlo_q};
	assign dxm_c = dx_c[VALUE_WIDTH] ? mag_t'(-dx_c) : mag_t'(dx_c);
	assign dym_c = dy_c[VALUE_WIDTH] ? mag_t'(-dy_c) : mag_t'(dy_c);
	assign am_c  = a_c[VALUE_WIDTH]  ? mag_t'(-a_c)  : mag_t'(a_c);

	plti_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.dividend(prod_q), .divisor(dxm_q),
		.done(div_done), .quotient(quo)
	);

	assign lim_hi = SUM_W'((1 <<< (VALUE_WIDTH - 1)) - 1);
	assign lim_lo = -SUM_W'(1 <<< (VALUE_WIDTH - 1));

	always_comb begin
		if (neg_q) begin
			sum_c = SUM_W'(ylo_q) - $signed({2'b00, quo});
		end else begin
			sum_c = SUM_W'(ylo_q) + $signed({2'b00, quo});
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (func == FUNC_QUERY) && (count_q >= CNT_W'(2))) begin
					state_d = S_SEL;
				end
			end
			S_SEL:   state_d = S_MUL;
			S_MUL:   state_d = (dx_c == '0) ? S_FIN : S_DIVGO;
			S_DIVGO: state_d = S_DIV;
			S_DIV:   state_d = div_done ? S_FIN : S_DIV;
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		busy   = 1'b1;
		div_go = 1'b0;
		case (state_q)
			S_IDLE:  busy = 1'b0;
			S_DIVGO: div_go = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if (accept) begin
				if (func != FUNC_QUERY || count_q < CNT_W'(2)) begin
					done <= 1'b1;
				end
				if (func == FUNC_CLEAR) begin
					count_q <= '0;
				end else if (cmd.load) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == S_FIN) begin
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q        <= value_t'(point_x);
			result_y    <= '0;
			segment_low <= '0;
			status      <= ST_OK;
			if (func == FUNC_LOAD && full) begin
				status <= ST_FULL;
			end else if (func == FUNC_QUERY && count_q < CNT_W'(2)) begin
				status <= ST_FEW;
			end
		end
		if (state_q == S_SEL) begin
			xlo_q <= xlo_c;
			xhi_q <= xhi_c;
			ylo_q <= ylo_c;
			yhi_q <= yhi_c;
			seg_q <= seg_c;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_t'(am_c) * prod_t'(dym_c);
			dxm_q  <= dxm_c;
			neg_q  <= (a_c[VALUE_WIDTH] != dy_c[VALUE_WIDTH]) != dx_c[VALUE_WIDTH];
			zero_q <= (dx_c == '0);
		end
		if (state_q == S_FIN) begin
			segment_low <= 8'(seg_q);
			if (zero_q) begin
				result_y <= ylo_q;
				status   <= ST_ZERO;
			end else if (sum_c > lim_hi) begin
				result_y <= value_t'(lim_hi);
				status   <= ST_SAT;
			end else if (sum_c < lim_lo) begin
				result_y <= value_t'(lim_lo);
				status   <= ST_SAT;
			end else begin
				result_y <= value_t'(sum_c);
				status   <= ST_OK;
			end
		end
	end

endmodule

// ----- rtl/core/plti_cell.sv -----
// One table cell: holds a breakpoint and shifts up when a smaller one is inserted below it.
module plti_cell (
	input  logic                clk,
	input  plti_pkg::cell_cmd_t cmd,
	input  logic                valid,
	input  logic                prev_le,
	input  plti_pkg::value_t    prev_x,
	input  plti_pkg::value_t    prev_y,
	output plti_pkg::value_t    x,
	output plti_pkg::value_t    y,
	output logic                le,
	output logic                gt
);
	import plti_pkg::*;

	value_t x_q;
	value_t y_q;

	assign le = valid && (x_q <= cmd.px);
	assign gt = valid && (cmd.px > x_q);
	assign x  = x_q;
	assign y  = y_q;

	// The new pair lands in the first empty cell or cell whose x exceeds it; cells above shift up.
	always_ff @(posedge clk) begin
		if (cmd.load && !le) begin
			if (prev_le) begin
				x_q <= cmd.px;
				y_q <= cmd.py;
			end else begin
				x_q <= prev_x;
				y_q <= prev_y;
			end
		end
	end

endmodule

// ----- rtl/core/plti_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module plti_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  plti_pkg::prod_t   dividend,
	input  plti_pkg::mag_t    divisor,
	output logic              done,
	output plti_pkg::prod_t   quotient
);
	import plti_pkg::*;

	logic              run_q;
	logic [STEP_W-1:0] cnt_q;
	mag_t              rem_q;
	mag_t              div_q;
	prod_t             quo_q;
	logic [VALUE_WIDTH:0] shifted;
	logic [VALUE_WIDTH:0] trial;
	logic                 fits;

	assign shifted = {rem_q, quo_q[PROD_W-1]};
	assign trial   = shifted - {1'b0, div_q};
	assign fits    = !trial[VALUE_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(PROD_W - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? trial[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule
